>>> rtl/core/assert_macros.svh
// assertion macros used by the top rtl file of the classifier
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/ncc_pkg.sv
// shared constants, types and reset table of the nearest centroid classifier
// no dependencies
`default_nettype none

package ncc_pkg;

  localparam int NUM_CENTRES = 6;
  localparam int COUNT_BITS  = 16;
  localparam int MAX_CENTRES = 8;

  localparam int AXIS_W     = 12;
  localparam int CENTRE_W   = 3 * AXIS_W;
  localparam int PROD_W     = 2 * AXIS_W;
  localparam int DIST_W     = 26;
  localparam int WINNER_W   = 3;
  localparam int CNT_OUT_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int IDX_W      = (NUM_CENTRES > 1) ? $clog2(NUM_CENTRES) : 1;
  localparam int IN_DATA_W  = ((CENTRE_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = WINNER_W + DIST_W + CNT_OUT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CENTRE_W-1:0] CENTRE_RESET [MAX_CENTRES] = '{
    36'd25406854328, 36'd25255802634, 36'd23878936030,
    36'd27152803315, 36'd20894127587, 36'd30305355236, 36'd0, 36'd0
  };

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             load_sample;
    logic             issue;
    logic [IDX_W-1:0] cen;
    axis_t            axis;
    logic             finish;
    logic             clear;
  } ncc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } ncc_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ncc_ctrl.sv
// controller fsm: sequences the centre/axis products, drain, count update or clear
// depends on ncc_pkg
`default_nettype none

module ncc_ctrl import ncc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      in_cmd,
  input  wire ncc_stat_t stat,
  output ncc_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CALC   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_FINISH = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cen_r, cen_nxt;
  axis_t            axis_r, axis_nxt;

  always_comb begin
    state_nxt       = state_r;
    cen_nxt         = cen_r;
    axis_nxt        = axis_r;
    in_tready       = 1'b0;
    cmd.load_sample = 1'b0;
    cmd.issue       = 1'b0;
    cmd.cen         = cen_r;
    cmd.axis        = axis_r;
    cmd.finish      = 1'b0;
    cmd.clear       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cen_nxt   = '0;
        axis_nxt  = AXIS_X;
        if (in_tvalid) begin
          cmd.load_sample = 1'b1;
          state_nxt = (in_cmd == CMD_CLEAR) ? S_CLEAR : S_CALC;
        end
      end
      S_CALC: begin
        cmd.issue = 1'b1;
        case (axis_r)
          AXIS_X:  axis_nxt = AXIS_Y;
          AXIS_Y:  axis_nxt = AXIS_Z;
          default: begin
            axis_nxt = AXIS_X;
            if (cen_r == IDX_W'(NUM_CENTRES - 1)) begin
              state_nxt = S_DRAIN;
            end else begin
              cen_nxt = cen_r + 1'b1;
            end
          end
        endcase
      end
      // last product is summed and compared here
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (stat.slot_free) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cen_r   <= '0;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      cen_r   <= cen_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ncc_datapath.sv
// datapath: centre registers, shared multiplier, accumulate/compare, counts,
// output register; depends on ncc_pkg
`default_nettype none

module ncc_datapath import ncc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CENTRE_W-1:0]   cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire ncc_cmd_t              cmd,
  output ncc_stat_t                  stat,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [CENTRE_W-1:0]   centre_r [NUM_CENTRES];
  logic [COUNT_BITS-1:0] count_r  [NUM_CENTRES];
  logic [CENTRE_W-1:0]   sample_r;

  logic                  p_vld_r;
  logic [IDX_W-1:0]      p_cen_r;
  axis_t                 p_axis_r;
  logic [PROD_W-1:0]     prod_r, prod_nxt;

  logic [DIST_W-1:0]     acc_r, sum;
  logic [DIST_W-1:0]     best_r;
  logic [IDX_W-1:0]      best_idx_r;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [AXIS_W-1:0]     s_ax, c_ax, diff;
  logic [CENTRE_W-1:0]   c_sel;

  logic [COUNT_BITS-1:0]           cnt_cur, cnt_new;
  logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_ext;
  logic [IDX_W+WINNER_W-1:0]       win_ext;

  // configuration writes beyond the centre list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CENTRES; i++) begin
        centre_r[i] <= CENTRE_RESET[i];
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CENTRES))) begin
      centre_r[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_r <= in_tdata[CENTRE_W-1:0];
    end
  end

  // product stage: |s - c| squared for one centre and axis
  always_comb begin
    c_sel = centre_r[cmd.cen];
    case (cmd.axis)
      AXIS_X: begin
        s_ax = sample_r[AXIS_W-1:0];
        c_ax = c_sel[AXIS_W-1:0];
      end
      AXIS_Y: begin
        s_ax = sample_r[2*AXIS_W-1:AXIS_W];
        c_ax = c_sel[2*AXIS_W-1:AXIS_W];
      end
      default: begin
        s_ax = sample_r[3*AXIS_W-1:2*AXIS_W];
        c_ax = c_sel[3*AXIS_W-1:2*AXIS_W];
      end
    endcase
    diff     = (s_ax > c_ax) ? (s_ax - c_ax) : (c_ax - s_ax);
    prod_nxt = PROD_W'(diff) * PROD_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r   <= prod_nxt;
      p_cen_r  <= cmd.cen;
      p_axis_r <= cmd.axis;
    end
  end

  // accumulate stage, strict compare keeps the lowest index on a tie
  assign sum = DIST_W'(prod_r) + ((p_axis_r == AXIS_X) ? DIST_W'(0) : acc_r);

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= sum;
      if (p_axis_r == AXIS_Z && (p_cen_r == '0 || sum < best_r)) begin
        best_r     <= sum;
        best_idx_r <= p_cen_r;
      end
    end
  end

  assign cnt_cur = count_r[best_idx_r];
  assign cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_new};
  assign win_ext = {{WINNER_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CENTRES; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_CENTRES; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      count_r[best_idx_r] <= cnt_new;
    end
  end

  // output register; a result waits here until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish || cmd.clear) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      out_data_r <= '0;
    end else if (cmd.finish) begin
      out_data_r <= OUT_DATA_W'({cnt_ext[CNT_OUT_W-1:0], best_r, win_ext[WINNER_W-1:0]});
    end
  end

  assign stat.slot_free = !out_vld_r || out_tready;
  assign out_tvalid     = out_vld_r;
  assign out_tdata      = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/nearest_centroid_classifier.sv
// classify: the single shared multiplier makes three products per centre in turn, and
// the summed distances are compared; no new item is accepted until the result is committed
// clear: all class counts go to zero and an all-zero result is committed
// results wait in an output register; the block is ready again once it is free
// synchronous active-low reset: centres to defaults, counts to zero, no result pending
// depends on ncc_pkg, ncc_ctrl, ncc_datapath and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nearest_centroid_classifier import ncc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CENTRE_W-1:0]   cfg_data,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // sample_x, sample_y, sample_z, pad
  input  wire logic                  in_tuser,   // cmd
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // winner, nearest_sq, class_count, pad
);

  ncc_cmd_t  cmd;
  ncc_stat_t stat;

  assign cfg_ready = 1'b1;

  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  ncc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // block is busy for the cycle after an accepted transfer
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a result is only committed into a free output slot
  `ASSERT_IMPL(a_commit_slot_free, clk, rst_n, cmd.finish || cmd.clear, stat.slot_free)
  // a new result only appears after a commit
  `ASSERT_IMPL(a_valid_from_commit, clk, rst_n, $rose(out_tvalid), $past(cmd.finish || cmd.clear))
  // no products are issued while idle
  `ASSERT_IMPL(a_no_issue_idle, clk, rst_n, in_tready, !cmd.issue)

endmodule

`default_nettype wire

>>> tb/ncc_checker.sv
`timescale 1ns / 1ps
// result checker for the nearest centroid classifier: mirrors centre writes and class
// counts, predicts every result and compares it field by field; depends on ncc_pkg
module ncc_checker import ncc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CENTRE_W-1:0]   cfg_data,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // sample_x, sample_y, sample_z, pad
  input  wire logic                  in_tuser,   // cmd
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // winner, nearest_sq, class_count, pad
  output int                         n_pending,
  output int                         n_errors
);

  typedef struct packed {
    logic [WINNER_W-1:0]  winner;
    logic [DIST_W-1:0]    distance;
    logic [CNT_OUT_W-1:0] count;
  } class_result_t;

  logic [CENTRE_W-1:0]   centre_copy [NUM_CENTRES];
  logic [COUNT_BITS-1:0] class_tally [NUM_CENTRES];
  class_result_t         expected_results [$];
  int                    errors = 0;

  function automatic logic [DIST_W-1:0] axis_sq(input logic [AXIS_W-1:0] a,
                                                input logic [AXIS_W-1:0] b);
    logic [DIST_W-1:0] d;
    d = (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
    return d * d;
  endfunction

  // nearest centre by strict compare, so the lowest index keeps a tie
  function automatic class_result_t nearest_centre(input logic [AXIS_W-1:0] sx,
                                                   input logic [AXIS_W-1:0] sy,
                                                   input logic [AXIS_W-1:0] sz);
    class_result_t     r;
    logic [DIST_W-1:0] sq_sum;
    int                i;
    r = '0;
    for (i = 0; i < NUM_CENTRES; i++) begin
      sq_sum = axis_sq(sx, centre_copy[i][0 +: AXIS_W])
             + axis_sq(sy, centre_copy[i][AXIS_W +: AXIS_W])
             + axis_sq(sz, centre_copy[i][2*AXIS_W +: AXIS_W]);
      if (i == 0 || sq_sum < r.distance) begin
        r.distance = sq_sum;
        r.winner   = WINNER_W'(i);
      end
    end
    if (class_tally[r.winner] != COUNT_MAX) class_tally[r.winner]++;
    r.count = CNT_OUT_W'(class_tally[r.winner]);
    return r;
  endfunction

  task automatic flag_error(input string what, input class_result_t want,
                            input class_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t ns %s: expected winner %0d dist %0d count %0d, %s %0d dist %0d count %0d",
               $time, what, want.winner, want.distance, want.count,
               "got winner", got.winner, got.distance, got.count);
  endtask

  always @(posedge clk) begin
    class_result_t want;
    class_result_t got;
    int            i;
    if (!rst_n) begin
      for (i = 0; i < NUM_CENTRES; i++) begin
        centre_copy[i] = CENTRE_RESET[i];
        class_tally[i] = '0;
      end
      expected_results.delete();
    end else begin
      // indexes past the last centre are dropped by the block
      if (cfg_valid && cfg_ready && cfg_index < NUM_CENTRES)
        centre_copy[cfg_index] = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_CLEAR) begin
          for (i = 0; i < NUM_CENTRES; i++) class_tally[i] = '0;
          expected_results.push_back('0);
        end else begin
          expected_results.push_back(nearest_centre(in_tdata[0 +: AXIS_W],
                                                    in_tdata[AXIS_W +: AXIS_W],
                                                    in_tdata[2*AXIS_W +: AXIS_W]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.winner   = out_tdata[0 +: WINNER_W];
        got.distance = out_tdata[WINNER_W +: DIST_W];
        got.count    = out_tdata[WINNER_W+DIST_W +: CNT_OUT_W];
        if (expected_results.size() == 0) begin
          flag_error("result transfer with nothing due", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.winner !== want.winner || got.distance !== want.distance ||
              got.count !== want.count)
            flag_error("result mismatch", want, got);
        end
      end
    end
    n_pending <= expected_results.size();
    n_errors  <= errors;
  end

endmodule

>>> tb/nearest_centroid_classifier_tb.sv
`timescale 1ns / 1ps
// top of the nearest centroid classifier testbench: clock, reset, centre settings,
// sample stimulus and output back-pressure; depends on ncc_pkg, ncc_checker and the block
module nearest_centroid_classifier_tb;
  import ncc_pkg::*;

  localparam int AXIS_MAX = (1 << AXIS_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CENTRE_W-1:0]   cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // sample_x, sample_y, sample_z, pad
  logic                  in_tuser = CMD_CLASSIFY;  // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // winner, nearest_sq, class_count, pad

  int n_pending;
  int n_errors;

  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  logic [CENTRE_W-1:0] centre_now [NUM_CENTRES];
  logic [CENTRE_W-1:0] next_centres [NUM_CENTRES];
  int n_classify = 0;
  int n_clear = 0;
  int n_writes = 0;
  int n_settings = 0;

  nearest_centroid_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ncc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_pending  (n_pending),
    .n_errors   (n_errors)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("nearest_centroid_classifier_tb: done, errors");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= 300;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  function automatic logic [AXIS_W-1:0] clamp_axis(input int v);
    if (v < 0) return '0;
    if (v > AXIS_MAX) return AXIS_W'(AXIS_MAX);
    return AXIS_W'(v);
  endfunction

  function automatic logic [CENTRE_W-1:0] pick_sample();
    logic [CENTRE_W-1:0] a;
    logic [CENTRE_W-1:0] b;
    logic [CENTRE_W-1:0] s;
    int                  k;
    a = centre_now[$urandom_range(0, NUM_CENTRES-1)];
    b = centre_now[$urandom_range(0, NUM_CENTRES-1)];
    s = CENTRE_W'({$urandom, $urandom});
    case ($urandom_range(0, 9)) inside
      [0:3]: ;
      [4:6]: begin
        for (k = 0; k < 3; k++)
          s[k*AXIS_W +: AXIS_W] = clamp_axis(int'(a[k*AXIS_W +: AXIS_W])
                                             + int'($urandom_range(0, 128)) - 64);
      end
      7: s = a;
      8: begin
        for (k = 0; k < 3; k++)
          s[k*AXIS_W +: AXIS_W] = $urandom_range(0, 1) ? AXIS_W'(AXIS_MAX) : '0;
      end
      default: begin
        // halfway between two centres, often an exact tie
        for (k = 0; k < 3; k++)
          s[k*AXIS_W +: AXIS_W] = AXIS_W'((int'(a[k*AXIS_W +: AXIS_W])
                                           + int'(b[k*AXIS_W +: AXIS_W])) / 2);
      end
    endcase
    return s;
  endfunction

  // cfg_valid stays high across back-to-back writes
  task automatic write_centre(input int idx, input logic [CENTRE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_CENTRES) centre_now[idx] = value;
    n_writes++;
  endtask

  task automatic load_centres();
    int i;
    for (i = 0; i < NUM_CENTRES; i++) write_centre(i, next_centres[i]);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_item(input logic cmd, input logic [CENTRE_W-1:0] xyz);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'(xyz);
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_CLEAR) n_clear++;
    else n_classify++;
  endtask

  // wait until every accepted item has produced its result
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  initial begin
    logic [CENTRE_W-1:0] base;
    logic                cmd;
    int                  phase;
    int                  n;
    int                  i;
    int                  k;
    for (i = 0; i < NUM_CENTRES; i++) centre_now[i] = CENTRE_RESET[i];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset centres: exact hits, both corners, clear with set sample bits
    send_item(CMD_CLASSIFY, CENTRE_RESET[0]);
    send_item(CMD_CLASSIFY, '0);
    send_item(CMD_CLASSIFY, '1);
    send_item(CMD_CLASSIFY, CENTRE_RESET[5]);
    send_item(CMD_CLEAR, '1);
    send_item(CMD_CLASSIFY, CENTRE_RESET[5]);
    drain();

    // all centres at the origin, writes past the last centre must be dropped
    write_centre(6, '1);
    write_centre(7, '1);
    write_centre((1 << CFG_IDX_W) - 1, '1);
    for (i = 0; i < NUM_CENTRES; i++) next_centres[i] = '0;
    load_centres();
    send_item(CMD_CLASSIFY, '1);
    send_item(CMD_CLASSIFY, '0);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_CLASSIFY, '1);
    drain();

    // corners of the cube, centre 5 duplicates centre 1
    next_centres[0] = '1;
    next_centres[1] = '0;
    next_centres[2] = CENTRE_W'(AXIS_MAX);
    next_centres[3] = CENTRE_W'(AXIS_MAX) << AXIS_W;
    next_centres[4] = CENTRE_W'(AXIS_MAX) << (2*AXIS_W);
    next_centres[5] = '0;
    load_centres();
    send_item(CMD_CLASSIFY, '0);
    send_item(CMD_CLASSIFY, '1);
    send_item(CMD_CLASSIFY, next_centres[2]);
    send_item(CMD_CLASSIFY, next_centres[3]);
    send_item(CMD_CLASSIFY, next_centres[4]);
    send_item(CMD_CLASSIFY, {12'd2048, 12'd2047, 12'd2048});
    send_item(CMD_CLASSIFY, '0);

    for (phase = 0; phase < 5; phase++) begin
      drain();
      base = CENTRE_W'({$urandom, $urandom});
      for (i = 0; i < NUM_CENTRES; i++) begin
        case (phase)
          0: next_centres[i] = CENTRE_RESET[i];
          2: begin
            // tight cluster, many near ties
            for (k = 0; k < 3; k++)
              next_centres[i][k*AXIS_W +: AXIS_W] =
                clamp_axis(int'(base[k*AXIS_W +: AXIS_W]) + int'($urandom_range(0, 80)) - 40);
          end
          3: begin
            for (k = 0; k < 3; k++)
              case ($urandom_range(0, 2))
                0: next_centres[i][k*AXIS_W +: AXIS_W] = '0;
                1: next_centres[i][k*AXIS_W +: AXIS_W] = AXIS_W'(AXIS_MAX);
                default: next_centres[i][k*AXIS_W +: AXIS_W] = AXIS_W'($urandom);
              endcase
          end
          default: next_centres[i] = CENTRE_W'({$urandom, $urandom});
        endcase
      end
      if (phase == 2) next_centres[3] = next_centres[1];
      if (phase == 4) begin
        write_centre(6, CENTRE_W'({$urandom, $urandom}));
        write_centre(7, CENTRE_W'({$urandom, $urandom}));
        write_centre($urandom_range(NUM_CENTRES, (1 << CFG_IDX_W) - 1),
                     CENTRE_W'({$urandom, $urandom}));
      end
      load_centres();
      calm <= (phase == 1);
      for (n = 0; n < 200; n++) begin
        if (phase == 3 && n == 40) hold_go <= 1'b1;
        cmd = ($urandom_range(0, 99) < 4) ? CMD_CLEAR : CMD_CLASSIFY;
        send_item(cmd, pick_sample());
      end
    end

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d classifications and %0d clears under %0d centre settings",
             n_classify, n_clear, n_settings);
    $display("%0d centre register writes, including indexes past the last centre", n_writes);
    if (n_errors == 0 && n_pending == 0) begin
      $display("nearest_centroid_classifier_tb: done, clean");
    end else begin
      $display("nearest_centroid_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ncc_pkg.sv
rtl/core/ncc_ctrl.sv
rtl/core/ncc_datapath.sv
rtl/core/nearest_centroid_classifier.sv
tb/ncc_checker.sv
tb/nearest_centroid_classifier_tb.sv
